/* design/cosine_similarity_engine_unit_macros.svh */
// assertion macros shared by the cosine similarity checker
// no dependencies; included by bare file name
`ifndef COSINE_SIMILARITY_ENGINE_UNIT_MACROS_SVH
`define COSINE_SIMILARITY_ENGINE_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CSIM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define CSIM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/csim_pkg.sv */
// shared widths, sequencer states and step codes of the cosine similarity engine
// no dependencies; imported by every module of the block
package csim_pkg;

    localparam int ELEM_W     = 15;
    localparam int COS_W      = 16;
    localparam int ACC_W      = 40;
    localparam int LIMB_W     = ACC_W / 2;
    localparam int MUL_W      = LIMB_W + 1;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int WIDE_W     = 2 * ACC_W;
    localparam int ROOT_W     = 14;
    localparam int Q_W        = ROOT_W + 1;
    localparam int QUOT_W     = 2 * ROOT_W;
    localparam int DIV_STEPS  = QUOT_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);
    localparam int CNT_W      = 4;

    // +1.0 in Q1.14
    localparam logic [Q_W-1:0]          Q_ONE   = Q_W'(1) << ROOT_W;
    localparam logic signed [COS_W-1:0] COS_MAX = COS_W'(Q_ONE);

    // element product steps of the multiply-accumulate phase
    localparam logic [CNT_W-1:0] STEP_AB  = CNT_W'(0);
    localparam logic [CNT_W-1:0] STEP_AA  = CNT_W'(1);
    localparam logic [CNT_W-1:0] STEP_BB  = CNT_W'(2);
    localparam logic [CNT_W-1:0] MAC_LAST = CNT_W'(3);
    // eight limb products, the last one retired in the cycle after its issue
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(8);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_PREP,
        ST_MUL,
        ST_CMP,
        ST_DIV,
        ST_SQRT,
        ST_WRITE
    } t_state;

endpackage

/* design/cosine_similarity_engine_unit.sv */
// cosine similarity engine: top level with sequencer, accumulators and output register
// non-last transaction: o_ready returns after the multiply-accumulate phase, not before
// last transaction: o_valid rises after the limb products, the 28-step divider and the
//   14-step square root, after the limb products alone on saturation, or after the sums on a zero norm
// synchronous active-low reset clears sequencer, accumulators and output valid
// depends on csim_pkg, csim_mul, csim_div, csim_sqrt
module cosine_similarity_engine_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [csim_pkg::ELEM_W-1:0]  i_elem_a,
    input  logic signed [csim_pkg::ELEM_W-1:0]  i_elem_b,
    input  logic                                i_last,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [csim_pkg::COS_W-1:0]   o_cosine
);
    import csim_pkg::*;

    // sequencer
    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic [CNT_W-1:0]         w_idx;

    // captured transaction
    logic signed [ELEM_W-1:0] r_elem_a, n_elem_a;
    logic signed [ELEM_W-1:0] r_elem_b, n_elem_b;
    logic                     r_last, n_last;

    // running sums, wrap modulo 2^40
    logic [ACC_W-1:0]         r_dot, n_dot;
    logic [ACC_W-1:0]         r_norm_a, n_norm_a;
    logic [ACC_W-1:0]         r_norm_b, n_norm_b;

    // finishing datapath
    logic                     r_neg, n_neg;
    logic [ACC_W-1:0]         r_mag, n_mag;
    logic [WIDE_W-1:0]        r_lsq, n_lsq;       // |dot| squared
    logic [WIDE_W-1:0]        r_pnorm, n_pnorm;   // norm_a * norm_b
    logic [Q_W-1:0]           r_q, n_q;

    // output register
    logic                     r_out_valid, n_out_valid;
    logic [COS_W-1:0]         r_cos, n_cos;

    // shared multiplier and iterative units
    logic signed [MUL_W-1:0]  w_op_a, w_op_b;
    logic signed [PROD_W-1:0] w_prod;
    logic [WIDE_W-1:0]        w_pp;
    logic [WIDE_W-1:0]        w_pp_sh;
    logic                     w_div_start;
    logic                     w_div_done;
    logic [QUOT_W-1:0]        w_quot;
    logic                     w_sqrt_start;
    logic                     w_sqrt_done;
    logic [ROOT_W-1:0]        w_root;

    logic                     w_accept;
    logic                     w_norm_zero;
    logic                     w_sat;

    assign w_accept    = i_valid && o_ready;
    assign w_idx       = r_cnt - CNT_W'(1);     // step whose product is ready now
    assign w_norm_zero = (r_norm_a == '0) || (r_norm_b == '0);
    // |dot|^2 >= norm product means the ratio reaches one: saturate
    assign w_sat       = (r_lsq >= r_pnorm);

    csim_mul u_mul (
        .i_clk  (i_clk),
        .i_op_a (w_op_a),
        .i_op_b (w_op_b),
        .o_prod (w_prod)
    );

    // (|dot|^2 << 28) / (norm_a * norm_b), known below 2^28 once not saturated
    csim_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_lsq),
        .i_den   (r_pnorm),
        .o_quot  (w_quot),
        .o_done  (w_div_done)
    );

    // floor of the root of that quotient is the Q1.14 magnitude
    csim_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_rad   (w_quot),
        .o_root  (w_root),
        .o_done  (w_sqrt_done)
    );

    // limb product placed by limb weight: low*low, cross terms, high*high
    assign w_pp = {{(WIDE_W-ACC_W){1'b0}}, w_prod[ACC_W-1:0]};

    always_comb begin
        case (w_idx[1:0])
            2'b00:   w_pp_sh = w_pp;
            2'b11:   w_pp_sh = w_pp << (2 * LIMB_W);
            default: w_pp_sh = w_pp << LIMB_W;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_MAC;
                end
            end
            ST_MAC: begin
                if (r_cnt == MAC_LAST) begin
                    n_state = r_last ? ST_PREP : ST_IDLE;
                end
            end
            ST_PREP: begin
                n_state = w_norm_zero ? ST_WRITE : ST_MUL;
            end
            ST_MUL: begin
                if (r_cnt == MUL_LAST) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                n_state = w_sat ? ST_WRITE : ST_DIV;
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (w_sqrt_done) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                // wait for a free output register
                if (!r_out_valid) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs: handshake, unit starts, multiplier operand routing
    always_comb begin
        o_ready      = 1'b0;
        w_div_start  = 1'b0;
        w_sqrt_start = 1'b0;
        w_op_a       = '0;
        w_op_b       = '0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
            end
            ST_MAC: begin
                // a*b, then a*a, then b*b
                w_op_a = (r_cnt == STEP_BB) ? MUL_W'(r_elem_b) : MUL_W'(r_elem_a);
                w_op_b = (r_cnt == STEP_AA) ? MUL_W'(r_elem_a) : MUL_W'(r_elem_b);
            end
            ST_MUL: begin
                // counter bit 2 picks the product, bits 1 and 0 pick the limbs
                if (r_cnt[2]) begin
                    w_op_a = r_cnt[1] ? {1'b0, r_norm_a[ACC_W-1:LIMB_W]}
                                      : {1'b0, r_norm_a[LIMB_W-1:0]};
                    w_op_b = r_cnt[0] ? {1'b0, r_norm_b[ACC_W-1:LIMB_W]}
                                      : {1'b0, r_norm_b[LIMB_W-1:0]};
                end else begin
                    w_op_a = r_cnt[1] ? {1'b0, r_mag[ACC_W-1:LIMB_W]}
                                      : {1'b0, r_mag[LIMB_W-1:0]};
                    w_op_b = r_cnt[0] ? {1'b0, r_mag[ACC_W-1:LIMB_W]}
                                      : {1'b0, r_mag[LIMB_W-1:0]};
                end
            end
            ST_CMP: begin
                w_div_start = !w_sat;
            end
            ST_DIV: begin
                w_sqrt_start = w_div_done;
            end
            default: ;
        endcase
    end

    // datapath next values
    always_comb begin
        n_cnt       = r_cnt;
        n_elem_a    = r_elem_a;
        n_elem_b    = r_elem_b;
        n_last      = r_last;
        n_dot       = r_dot;
        n_norm_a    = r_norm_a;
        n_norm_b    = r_norm_b;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_lsq       = r_lsq;
        n_pnorm     = r_pnorm;
        n_q         = r_q;
        n_cos       = r_cos;
        n_out_valid = r_out_valid;

        if (o_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_elem_a = i_elem_a;
                    n_elem_b = i_elem_b;
                    n_last   = i_last;
                    n_cnt    = '0;
                end
            end
            ST_MAC: begin
                n_cnt = r_cnt + CNT_W'(1);
                case (w_idx)
                    STEP_AB: n_dot    = r_dot + w_prod[ACC_W-1:0];
                    STEP_AA: n_norm_a = r_norm_a + w_prod[ACC_W-1:0];
                    STEP_BB: n_norm_b = r_norm_b + w_prod[ACC_W-1:0];
                    default: ;
                endcase
            end
            ST_PREP: begin
                n_cnt   = '0;
                n_lsq   = '0;
                n_pnorm = '0;
                n_mag   = r_dot[ACC_W-1] ? (ACC_W'(0) - r_dot) : r_dot;
                n_neg   = r_dot[ACC_W-1];
                if (w_norm_zero) begin
                    // a zero norm gives a zero result
                    n_q   = '0;
                    n_neg = 1'b0;
                end
            end
            ST_MUL: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt != '0) begin
                    if (w_idx[2]) begin
                        n_pnorm = r_pnorm + w_pp_sh;
                    end else begin
                        n_lsq = r_lsq + w_pp_sh;
                    end
                end
            end
            ST_CMP: begin
                if (w_sat) begin
                    n_q = Q_ONE;
                end
            end
            ST_SQRT: begin
                if (w_sqrt_done) begin
                    n_q = {1'b0, w_root};
                end
            end
            ST_WRITE: begin
                if (!r_out_valid) begin
                    n_cos       = r_neg ? (COS_W'(0) - COS_W'(r_q)) : COS_W'(r_q);
                    n_out_valid = 1'b1;
                    n_dot       = '0;
                    n_norm_a    = '0;
                    n_norm_b    = '0;
                end
            end
            default: ;
        endcase
    end

    // control state and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_dot       <= '0;
            r_norm_a    <= '0;
            r_norm_b    <= '0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            r_dot       <= n_dot;
            r_norm_a    <= n_norm_a;
            r_norm_b    <= n_norm_b;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_elem_a <= n_elem_a;
        r_elem_b <= n_elem_b;
        r_last   <= n_last;
        r_neg    <= n_neg;
        r_mag    <= n_mag;
        r_lsq    <= n_lsq;
        r_pnorm  <= n_pnorm;
        r_q      <= n_q;
        r_cos    <= n_cos;
    end

    assign o_valid  = r_out_valid;
    assign o_cosine = r_cos;

endmodule

/* design/csim_mul.sv */
// shared signed multiplier with registered product
// depends on csim_pkg
module csim_mul (
    input  logic                                i_clk,
    input  logic signed [csim_pkg::MUL_W-1:0]   i_op_a,
    input  logic signed [csim_pkg::MUL_W-1:0]   i_op_b,
    output logic signed [csim_pkg::PROD_W-1:0]  o_prod
);
    import csim_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;

    assign n_prod = i_op_a * i_op_b;

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

/* design/csim_div.sv */
// restoring divider, one quotient bit per cycle, numerator below denominator
// depends on csim_pkg
module csim_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [csim_pkg::WIDE_W-1:0]    i_num,
    input  logic [csim_pkg::WIDE_W-1:0]    i_den,
    output logic [csim_pkg::QUOT_W-1:0]    o_quot,
    output logic                           o_done
);
    import csim_pkg::*;

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [DIV_CNT_W-1:0]  r_cnt, n_cnt;
    logic [WIDE_W-1:0]     r_rem, n_rem;
    logic [QUOT_W-1:0]     r_quot, n_quot;
    logic [WIDE_W:0]       w_rem2;
    logic [WIDE_W:0]       w_den;
    logic [WIDE_W:0]       w_diff;
    logic                  w_ge;
    logic                  w_last;

    assign w_rem2 = {r_rem, 1'b0};
    assign w_den  = {1'b0, i_den};
    assign w_diff = w_rem2 - w_den;
    assign w_ge   = (w_rem2 >= w_den);
    assign w_last = (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quot = r_quot;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = i_num;
            n_quot = '0;
        end else if (r_busy) begin
            n_rem  = w_ge ? w_diff[WIDE_W-1:0] : w_rem2[WIDE_W-1:0];
            n_quot = {r_quot[QUOT_W-2:0], w_ge};
            n_cnt  = r_cnt + DIV_CNT_W'(1);
            if (w_last) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_quot <= n_quot;
    end

    assign o_quot = r_quot;
    assign o_done = r_done;

endmodule

/* design/csim_sqrt.sv */
// digit-by-digit integer square root, one root bit per cycle
// depends on csim_pkg
module csim_sqrt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [csim_pkg::QUOT_W-1:0]    i_rad,
    output logic [csim_pkg::ROOT_W-1:0]    o_root,
    output logic                           o_done
);
    import csim_pkg::*;

    localparam int TRY_W = ROOT_W + 3;

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [SQRT_CNT_W-1:0] r_cnt, n_cnt;
    logic [QUOT_W-1:0]     r_rad, n_rad;
    logic [ROOT_W:0]       r_rem, n_rem;
    logic [ROOT_W-1:0]     r_root, n_root;
    logic [TRY_W-1:0]      w_part;
    logic [TRY_W-1:0]      w_trial;
    logic [TRY_W-1:0]      w_diff;
    logic                  w_ge;
    logic                  w_last;

    assign w_part  = {r_rem, r_rad[QUOT_W-1 -: 2]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_diff  = w_part - w_trial;
    assign w_ge    = (w_part >= w_trial);
    assign w_last  = (r_cnt == SQRT_CNT_W'(SQRT_STEPS - 1));

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rad  = i_rad;
            n_rem  = '0;
            n_root = '0;
        end else if (r_busy) begin
            n_rad  = r_rad << 2;
            n_rem  = w_ge ? w_diff[ROOT_W:0] : w_part[ROOT_W:0];
            n_root = {r_root[ROOT_W-2:0], w_ge};
            n_cnt  = r_cnt + SQRT_CNT_W'(1);
            if (w_last) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_root = r_root;
    assign o_done = r_done;

endmodule

/* design/csim_chk.sv */
// port-level checker for the cosine similarity engine, bound to the top level
// depends on csim_pkg and cosine_similarity_engine_unit_macros.svh
`include "cosine_similarity_engine_unit_macros.svh"

module csim_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_ready,
    input logic signed [csim_pkg::ELEM_W-1:0]  i_elem_a,
    input logic signed [csim_pkg::ELEM_W-1:0]  i_elem_b,
    input logic                                i_last,
    input logic                                o_valid,
    input logic                                i_ready,
    input logic signed [csim_pkg::COS_W-1:0]   o_cosine
);
    import csim_pkg::*;

    // a stalled result transaction keeps its value
    `CSIM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_cosine), "result changed while stalled")

    // result stays within plus and minus one
    `CSIM_ASSERT_NOW(a_cos_range, i_clk, i_rst_n, o_valid, (o_cosine <= COS_MAX) && (o_cosine >= -COS_MAX), "cosine outside range")

    // every input transaction takes the sequencer out of idle, so ready drops after acceptance
    `CSIM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "ready stayed high after input transaction")

    // one result register: a taken result is never followed by another at once
    `CSIM_ASSERT_NEXT(a_single_result, i_clk, i_rst_n, o_valid && i_ready, !o_valid, "result repeated after output transaction")

endmodule

bind cosine_similarity_engine_unit csim_chk u_csim_chk (.*);
